@@ design/key_change_event_encoder_assert.svh @@
// Assertion helpers for the key change event encoder
`ifndef KEY_CHANGE_EVENT_ENCODER_ASSERT_SVH
`define KEY_CHANGE_EVENT_ENCODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define KCE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("key change event encoder: check failed");

// next-cycle implication, disabled during reset
`define KCE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("key change event encoder: check failed");

`endif

@@ design/kce_pkg.sv @@
package kce_pkg;

   localparam int KEY_COUNT   = 78;
   localparam int PORT_COUNT  = 10;
   localparam int PORT_G      = 9;
   localparam int PIN_COUNT   = 8;
   localparam int BUTTON_BASE = 156;
   localparam int RX_BASE     = 182;
   localparam int RY_BASE     = 231;

   // input word kinds; the fourth code is unused
   typedef enum logic [1:0] {
      KIND_KEY    = 2'd0,
      KIND_BUTTON = 2'd1,
      KIND_JOY    = 2'd2
   } kind_type;

   typedef logic [7:0] code_type;

   // fixed key code of each pin, ports A,B,C,D,E,H,J,L,K,G
   localparam logic [6:0] KEY_CODE [PORT_COUNT][PIN_COUNT] = '{
      '{7'd21, 7'd34, 7'd60, 7'd48, 7'd61, 7'd7,  7'd71, 7'd22},
      '{7'd56, 7'd69, 7'd68, 7'd15, 7'd1,  7'd0,  7'd14, 7'd28},
      '{7'd73, 7'd72, 7'd52, 7'd64, 7'd63, 7'd51, 7'd37, 7'd24},
      '{7'd75, 7'd74, 7'd11, 7'd26, 7'd39, 7'd53, 7'd65, 7'd10},
      '{7'd46, 7'd4,  7'd18, 7'd31, 7'd45, 7'd57, 7'd44, 7'd30},
      '{7'd70, 7'd17, 7'd3,  7'd2,  7'd16, 7'd29, 7'd43, 7'd42},
      '{7'd9,  7'd62, 7'd50, 7'd36, 7'd23, 7'd8,  7'd49, 7'd76},
      '{7'd77, 7'd41, 7'd13, 7'd27, 7'd54, 7'd66, 7'd12, 7'd40},
      '{7'd5,  7'd19, 7'd58, 7'd47, 7'd33, 7'd20, 7'd6,  7'd59},
      '{7'd25, 7'd38, 7'd35, 7'd55, 7'd67, 7'd32, 7'd0,  7'd0}
   };

   // axis sample to event: v = round((2*adc-1023)*49/2048), half away from zero
   // returns {v != 0, base + v}
   function automatic logic [8:0] axis_event(input logic [9:0] sample,
                                             input code_type base);
      logic signed [11:0] diff;
      logic [10:0]        mag_diff;
      logic [16:0]        mag;
      logic [4:0]         q;
      code_type           code;
      diff     = $signed({1'b0, sample, 1'b0}) - 12'sd1023;
      mag_diff = diff[11] ? 11'(-diff) : 11'(diff);
      mag      = 17'(mag_diff) * 17'd49;
      q        = 5'((mag + 17'd1024) >> 11);
      code     = diff[11] ? (base - code_type'(q)) : (base + code_type'(q));
      return {q != 5'd0, code};
   endfunction

endpackage

@@ design/key_change_event_encoder.sv @@
// The first event word of an accepted input word is presented in the cycle after it is accepted.
// Throughput: one event word per cycle while rsp_stall is low; an input word
// causing no events leaves nothing pending, so the next word is not held off.
// A new input word is taken in the cycle the last pending event leaves.
// Reset (synchronous): all key levels high (released), button level high,
// no events pending.
module key_change_event_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [3:0] req_port_index,
   input  logic [7:0] req_port_bits,
   input  logic       req_button_level,
   input  logic [9:0] req_rx_sample,
   input  logic [9:0] req_ry_sample,
   input  logic       req_full_report,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_event_code,
   output logic       rsp_last_event
);

   // stored levels
   logic [7:0] key_levels_ff [kce_pkg::PORT_COUNT];
   logic       button_level_ff;

   // pending event slots, emitted lowest slot first
   logic [7:0]              pending_ff, pending_in;
   kce_pkg::code_type       codes_ff [kce_pkg::PIN_COUNT];
   kce_pkg::code_type       codes_in [kce_pkg::PIN_COUNT];

   logic       req_fire, rsp_fire;
   logic       port_ok;
   logic [3:0] port_sel;
   logic [7:0] pin_mask, old_levels, key_mask, new_levels;
   logic       key_write, button_write;
   logic [7:0] new_mask;
   logic [8:0] rx_event, ry_event;
   logic [2:0] slot_idx;
   logic [7:0] low_onehot;

   assign rsp_valid = |pending_ff;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   // take the next word once the last pending event leaves
   assign req_stall = rsp_valid && !(rsp_fire && rsp_last_event);
   assign req_fire  = req_valid && !req_stall;

   // output slot select
   always_comb begin
      slot_idx = 3'd0;
      for (int i = kce_pkg::PIN_COUNT - 1; i >= 0; i--) begin
         if (pending_ff[i]) slot_idx = 3'(i);
      end
   end
   assign low_onehot     = pending_ff & (~pending_ff + 8'd1);
   assign rsp_event_code = codes_ff[slot_idx];
   assign rsp_last_event = (pending_ff & (pending_ff - 8'd1)) == 8'd0;

   assign rx_event = kce_pkg::axis_event(req_rx_sample, 8'(kce_pkg::RX_BASE));
   assign ry_event = kce_pkg::axis_event(req_ry_sample, 8'(kce_pkg::RY_BASE));

   // event decode of the incoming word
   always_comb begin
      port_ok    = req_port_index < 4'(kce_pkg::PORT_COUNT);
      port_sel   = port_ok ? req_port_index : 4'd0;
      pin_mask   = (port_sel == 4'(kce_pkg::PORT_G)) ? 8'h3F : 8'hFF;
      old_levels = key_levels_ff[port_sel];
      key_mask   = req_full_report ? pin_mask : ((req_port_bits ^ old_levels) & pin_mask);
      new_levels = (old_levels & ~key_mask) | (req_port_bits & key_mask);
      key_write    = 1'b0;
      button_write = 1'b0;
      new_mask     = 8'd0;
      for (int b = 0; b < kce_pkg::PIN_COUNT; b++) begin
         codes_in[b] = 8'(kce_pkg::KEY_CODE[port_sel][b])
                     + (req_port_bits[b] ? 8'(kce_pkg::KEY_COUNT) : 8'd0);
      end
      unique case (kce_pkg::kind_type'(req_kind))
         kce_pkg::KIND_KEY: begin
            key_write = port_ok;
            new_mask  = port_ok ? key_mask : 8'd0;
         end
         kce_pkg::KIND_BUTTON: begin
            button_write = req_full_report || (req_button_level != button_level_ff);
            new_mask     = {7'd0, button_write};
            codes_in[0]  = 8'(kce_pkg::BUTTON_BASE) + {7'd0, req_button_level};
         end
         kce_pkg::KIND_JOY: begin
            new_mask    = {6'd0, ry_event[8], rx_event[8]};
            codes_in[0] = rx_event[7:0];
            codes_in[1] = ry_event[7:0];
         end
         default: begin
            new_mask = 8'd0;
         end
      endcase
   end

   // pending slot update
   always_comb begin
      if (req_fire) begin
         pending_in = new_mask;
      end else if (rsp_fire) begin
         pending_in = pending_ff & ~low_onehot;
      end else begin
         pending_in = pending_ff;
      end
   end

   // control and stored levels
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= 8'd0;
         button_level_ff <= 1'b1;
         for (int p = 0; p < kce_pkg::PORT_COUNT; p++) begin
            key_levels_ff[p] <= 8'hFF;
         end
      end else begin
         pending_ff <= pending_in;
         if (req_fire && key_write) begin
            key_levels_ff[port_sel] <= new_levels;
         end
         if (req_fire && button_write) begin
            button_level_ff <= req_button_level;
         end
      end
   end

   // event code payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int b = 0; b < kce_pkg::PIN_COUNT; b++) begin
            codes_ff[b] <= codes_in[b];
         end
      end
   end

`include "key_change_event_encoder_assert.svh"

   // a new word only lands when the last pending event is leaving
   `KCE_ASSERT_IMPL(a_accept_on_last, clock, reset, req_fire && rsp_valid, rsp_fire && rsp_last_event)
   // an event that is not the last is followed by more
   `KCE_ASSERT_NEXT(a_more_follow, clock, reset, rsp_fire && !rsp_last_event, rsp_valid)
   // the two unused pins of port G keep their released level
   `KCE_ASSERT_IMPL(a_port_g_unused, clock, reset, 1'b1, key_levels_ff[kce_pkg::PORT_G][7:6] == 2'b11)

endmodule

@@ sim/key_change_event_encoder_test.sv @@
module key_change_event_encoder_test;

   timeunit 1ns;
   timeprecision 1ps;

   // unused kind code, not in the package enum
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   // cycles without any handshake before the run is declared hung
   localparam int QUIET_LIMIT = 3000;
   localparam int BACKPRESSURE_HOLD = 200;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] port;
      logic [7:0] bits;
      logic       button;
      logic [9:0] rx;
      logic [9:0] ry;
      logic       full;
   } sample_word_type;

   typedef struct packed {
      kce_pkg::code_type code;
      logic              last;
   } key_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_kind = '0;
   logic [3:0] req_port_index = '0;
   logic [7:0] req_port_bits = '0;
   logic       req_button_level = 1'b0;
   logic [9:0] req_rx_sample = '0;
   logic [9:0] req_ry_sample = '0;
   logic       req_full_report = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_event_code;
   logic       rsp_last_event;

   // shadow copy of the pin and button levels held by the block
   logic [7:0] shadow_key_levels [kce_pkg::PORT_COUNT];
   logic       shadow_button_level;

   key_event_type expected_events [$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            hold_left = 0;

   key_change_event_encoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_port_index   (req_port_index),
      .req_port_bits    (req_port_bits),
      .req_button_level (req_button_level),
      .req_rx_sample    (req_rx_sample),
      .req_ry_sample    (req_ry_sample),
      .req_full_report  (req_full_report),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_last_event   (rsp_last_event)
   );

   always #5 clock = ~clock;

   // joystick axis offset, rounded half away from zero, in -24..24
   function automatic int axis_offset(logic [9:0] sample);
      int scaled;
      int q;
      scaled = (2 * int'(sample) - 1023) * 49;
      q = ((scaled < 0 ? -scaled : scaled) + 1024) >>> 11;
      return scaled < 0 ? -q : q;
   endfunction

   // work out the events of one accepted word and update the shadow levels
   function automatic void encode_events(sample_word_type w);
      kce_pkg::code_type codes [$];
      int                pins;
      int                dx;
      int                dy;
      logic              lvl;
      key_event_type     ev;
      if (w.kind == kce_pkg::KIND_KEY && w.port < kce_pkg::PORT_COUNT) begin
         pins = (w.port == kce_pkg::PORT_G) ? 6 : kce_pkg::PIN_COUNT;
         for (int b = 0; b < pins; b++) begin
            lvl = w.bits[b];
            if (w.full || lvl != shadow_key_levels[w.port][b]) begin
               codes.push_back(kce_pkg::code_type'(int'(kce_pkg::KEY_CODE[w.port][b])
                                                   + kce_pkg::KEY_COUNT * int'(lvl)));
               shadow_key_levels[w.port][b] = lvl;
            end
         end
      end else if (w.kind == kce_pkg::KIND_BUTTON) begin
         if (w.full || w.button != shadow_button_level) begin
            codes.push_back(kce_pkg::code_type'(kce_pkg::BUTTON_BASE + int'(w.button)));
            shadow_button_level = w.button;
         end
      end else if (w.kind == kce_pkg::KIND_JOY) begin
         dx = axis_offset(w.rx);
         dy = axis_offset(w.ry);
         if (dx != 0) codes.push_back(kce_pkg::code_type'(kce_pkg::RX_BASE + dx));
         if (dy != 0) codes.push_back(kce_pkg::code_type'(kce_pkg::RY_BASE + dy));
      end
      foreach (codes[i]) begin
         ev.code = codes[i];
         ev.last = (i == codes.size() - 1);
         expected_events.push_back(ev);
      end
   endfunction

   // offer one word, with random idle cycles ahead of it, until accepted
   task automatic send_word(sample_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= w.kind;
      req_port_index   <= w.port;
      req_port_bits    <= w.bits;
      req_button_level <= w.button;
      req_rx_sample    <= w.rx;
      req_ry_sample    <= w.ry;
      req_full_report  <= w.full;
      do @(posedge clock); while (req_stall);
      encode_events(w);
   endtask

   function automatic sample_word_type make_word(logic [1:0] kind, logic [3:0] port,
                                                 logic [7:0] bits, logic button,
                                                 logic [9:0] rx, logic [9:0] ry,
                                                 logic full);
      sample_word_type w;
      w.kind = kind;
      w.port = port;
      w.bits = bits;
      w.button = button;
      w.rx = rx;
      w.ry = ry;
      w.full = full;
      return w;
   endfunction

   // mostly key words, half of them single key flips, plus button, joystick, bad ports and noise
   function automatic sample_word_type random_word();
      sample_word_type w;
      int pick;
      pick = $urandom_range(99);
      w.kind = pick < 60 ? 2'(kce_pkg::KIND_KEY) : pick < 75 ? 2'(kce_pkg::KIND_BUTTON) :
               pick < 95 ? 2'(kce_pkg::KIND_JOY) : KIND_UNUSED;
      w.port = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                         : 4'($urandom_range(kce_pkg::PORT_COUNT - 1));
      if (w.port < kce_pkg::PORT_COUNT && $urandom_range(1) == 0)
         w.bits = shadow_key_levels[w.port] ^ (8'd1 << $urandom_range(7));
      else
         w.bits = 8'($urandom);
      w.button = 1'($urandom_range(1));
      w.rx = ($urandom_range(3) == 0) ? 10'($urandom_range(533, 490)) : 10'($urandom);
      w.ry = ($urandom_range(3) == 0) ? 10'($urandom_range(533, 490)) : 10'($urandom);
      w.full = ($urandom_range(6) == 0);
      return w;
   endfunction

   // stop offering and wait until every expected event has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
   endtask

   // every pin of a port flips, full reports, port G upper bits
   task automatic test_key_ports();
      send_word(make_word(kce_pkg::KIND_KEY, 4'd0, 8'h00, 1'b0, '0, '0, 1'b0));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd0, 8'hFF, 1'b1, '1, '1, 1'b1));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd0, 8'hFF, 1'b0, '0, '0, 1'b0));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd9, 8'h00, 1'b0, '0, '0, 1'b0));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd9, 8'hC0, 1'b0, '0, '0, 1'b1));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd9, 8'h3F, 1'b0, '0, '0, 1'b0));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd5, 8'hA5, 1'b0, '0, '0, 1'b0));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd8, 8'h5A, 1'b0, '0, '0, 1'b0));
      wait_drained();
   endtask

   // port index past G and the unused kind must change nothing
   task automatic test_ignored_words();
      send_word(make_word(kce_pkg::KIND_KEY, 4'd10, 8'h00, 1'b0, '0, '0, 1'b1));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd15, 8'h00, 1'b0, '0, '0, 1'b0));
      send_word(make_word(KIND_UNUSED, 4'd0, 8'h00, 1'b0, '0, '1, 1'b1));
      send_word(make_word(kce_pkg::KIND_KEY, 4'd0, 8'hFF, 1'b0, '0, '0, 1'b0));
      wait_drained();
   endtask

   task automatic test_button();
      send_word(make_word(kce_pkg::KIND_BUTTON, '0, '0, 1'b1, '0, '0, 1'b0));
      send_word(make_word(kce_pkg::KIND_BUTTON, '1, '1, 1'b0, '1, '1, 1'b0));
      send_word(make_word(kce_pkg::KIND_BUTTON, '0, '0, 1'b0, '0, '0, 1'b1));
      send_word(make_word(kce_pkg::KIND_BUTTON, '0, '0, 1'b1, '0, '0, 1'b0));
      wait_drained();
   endtask

   // axis extremes, dead center and a full report that must be ignored
   task automatic test_joystick();
      send_word(make_word(kce_pkg::KIND_JOY, '0, '0, 1'b0, 10'd0, 10'd1023, 1'b0));
      send_word(make_word(kce_pkg::KIND_JOY, '0, '0, 1'b0, 10'd1023, 10'd0, 1'b0));
      send_word(make_word(kce_pkg::KIND_JOY, '0, '0, 1'b0, 10'd511, 10'd512, 1'b0));
      send_word(make_word(kce_pkg::KIND_JOY, '0, '0, 1'b0, 10'd500, 10'd534, 1'b1));
      wait_drained();
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) send_word(random_word());
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering words
   task automatic test_backpressure();
      hold_left = BACKPRESSURE_HOLD;
      repeat (12) send_word(make_word(kce_pkg::KIND_KEY,
                                      4'($urandom_range(kce_pkg::PORT_COUNT - 1)),
                                      8'($urandom), 1'b0, '0, '0, 1'b1));
      wait_drained();
   endtask

   // receiver stall: long hold when requested, else random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // compare each accepted event word with the oldest expectation
   always @(posedge clock) begin
      key_event_type ev;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $display("%0t: event word expected none actual code %0d last %0b",
                     $time, rsp_event_code, rsp_last_event);
            error_count++;
         end else begin
            ev = expected_events.pop_front();
            if (rsp_event_code !== ev.code) begin
               $display("%0t: event_code expected %0d actual %0d",
                        $time, ev.code, rsp_event_code);
               error_count++;
            end
            if (rsp_last_event !== ev.last) begin
               $display("%0t: last_event expected %0b actual %0b",
                        $time, ev.last, rsp_last_event);
               error_count++;
            end
         end
      end
   end

   // hang detector
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("key_change_event_encoder_test: FAIL");
      $finish;
   end

   initial begin
      for (int p = 0; p < kce_pkg::PORT_COUNT; p++) shadow_key_levels[p] = 8'hFF;
      shadow_button_level = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_key_ports();
      test_ignored_words();
      test_button();
      test_joystick();

      send_idle_pct = 0;
      stall_pct = 0;
      test_random_traffic(35);
      send_idle_pct = 75;
      test_random_traffic(35);
      send_idle_pct = 0;
      stall_pct = 75;
      test_random_traffic(35);
      send_idle_pct = 32;
      stall_pct = 32;
      test_random_traffic(37);

      send_idle_pct = 0;
      stall_pct = 0;
      test_backpressure();

      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("key_change_event_encoder_test: PASS");
      end else begin
         $display("key_change_event_encoder_test: FAIL");
      end
      $finish;
   end

endmodule
